FILE: design/wsr_pkg.sv
`timescale 1ns / 1ps

package wsr_pkg;

	localparam int MAX_PATTERN_DEF  = 32;
	localparam int WINDOW_DEPTH_DEF = 64;
	localparam int QUEUE_DEPTH      = 4;
	localparam int SIG_BYTES        = 32;

	typedef enum logic [2:0] {
		CFG_PAT0   = 3'd0,
		CFG_PAT1   = 3'd1,
		CFG_PAT2   = 3'd2,
		CFG_PAT3   = 3'd3,
		CFG_LEN    = 3'd4,
		CFG_OFF    = 3'd5,
		CFG_ADDEND = 3'd6,
		CFG_BASE   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [8*SIG_BYTES-1:0] pattern;
		logic [5:0]             len;
		logic [5:0]             off;
		logic [31:0]            addend;
		logic [47:0]            base;
	} wsr_cfg_t;

	// one event handed from the classifier to the resolver
	typedef struct packed {
		logic        found;
		logic [31:0] pos;
		logic [31:0] disp;
	} wsr_evt_t;

	// clamp the displacement offset so the four displacement bytes fit the window
	function automatic logic [6:0] sat_offset(input logic [5:0] raw, input int unsigned wd);
		logic [6:0] lim;
		lim = 7'(wd - 4);
		if ({1'b0, raw} > lim) begin
			return lim;
		end
		return {1'b0, raw};
	endfunction

endpackage

FILE: design/wsr_front.sv
`timescale 1ns / 1ps

module wsr_front #(
	parameter int MAX_PATTERN  = 32,
	parameter int WINDOW_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wsr_pkg::wsr_cfg_t cfg,
	input  logic              in_valid,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              q_full,
	output logic              in_stall,
	output logic              push,
	output wsr_pkg::wsr_evt_t evt
);
	import wsr_pkg::*;

	localparam int L1  = (MAX_PATTERN < SIG_BYTES) ? MAX_PATTERN : SIG_BYTES;
	localparam int LIM = (WINDOW_DEPTH < L1) ? WINDOW_DEPTH : L1;
	localparam int AW  = $clog2(WINDOW_DEPTH);

	logic [7:0]     win_q [WINDOW_DEPTH];
	logic [7:0]     win_nx [WINDOW_DEPTH];
	logic [31:0]    cnt_q;
	logic           done_q;
	logic [LIM-1:0] lane_ok;
	logic [31:0]    disp;
	logic [31:0]    span_m1;
	logic           test;
	logic           hit;
	logic           emit;
	logic           accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		win_nx[0] = data_byte;
		for (int k = 1; k < WINDOW_DEPTH; k++) begin
			win_nx[k] = win_q[k-1];
		end
	end

	// lane compare against the window as it stands after this byte shifts in
	always_comb begin
		int unsigned raw_len;
		int unsigned len_i;
		int unsigned off_i;
		int unsigned span_i;
		logic [7:0]  sig;
		raw_len = 32'(cfg.len);
		len_i   = (raw_len == 0) ? 1 : ((raw_len > LIM) ? LIM : raw_len);
		off_i   = 32'(sat_offset(cfg.off, WINDOW_DEPTH));
		span_i  = (off_i + 4 > len_i) ? off_i + 4 : len_i;
		span_m1 = 32'(span_i - 1);
		for (int i = 0; i < LIM; i++) begin
			sig = cfg.pattern[i*8 +: 8];
			lane_ok[i] = (sig == 8'h00) || (i >= len_i) ||
				(win_nx[AW'(span_i - 1 - i)] == sig);
		end
		for (int k = 0; k < 4; k++) begin
			disp[k*8 +: 8] = win_nx[AW'(span_i - 1 - off_i - k)];
		end
	end

	assign test = !done_q && (cnt_q >= span_m1);
	assign hit  = test && (&lane_ok);
	assign emit = hit || (last_byte && !done_q);
	assign push = accept && emit;

	always_comb begin
		evt.found = hit;
		evt.pos   = hit ? (cnt_q - span_m1) : 32'd0;
		evt.disp  = disp;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < WINDOW_DEPTH; k++) begin
				win_q[k] <= win_nx[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				cnt_q  <= '0;
				done_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 32'd1;
				if (hit) begin
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: design/wsr_fifo.sv
`timescale 1ns / 1ps

module wsr_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsr_pkg::wsr_evt_t din,
	output logic              full,
	input  logic              pop,
	output wsr_pkg::wsr_evt_t dout,
	output logic              empty
);
	import wsr_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	wsr_evt_t    mem_q [QUEUE_DEPTH];
	logic [PW:0] wr_q;
	logic [PW:0] rd_q;

	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[PW-1:0] == rd_q[PW-1:0]) && (wr_q[PW] != rd_q[PW]);
	assign dout  = mem_q[rd_q[PW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q[PW-1:0]] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

endmodule

FILE: design/wsr_back.sv
`timescale 1ns / 1ps

module wsr_back #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wsr_pkg::wsr_cfg_t cfg,
	input  wsr_pkg::wsr_evt_t head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [31:0]       match_position,
	output logic [47:0]       target_address
);
	import wsr_pkg::*;

	logic        en;
	logic        v_s1;
	logic        found_s1;
	logic [31:0] pos_s1;
	logic [47:0] rel_s1;
	logic        vo_q;
	logic        found_q;
	logic [31:0] pos_q;
	logic [47:0] tgt_q;
	logic [47:0] rel_nx;
	logic [6:0]  off_e;

	assign en  = !(vo_q && out_stall);
	assign pop = en && !empty;

	assign off_e  = sat_offset(cfg.off, WINDOW_DEPTH);
	assign rel_nx = 48'(head.pos) + 48'(off_e) + {{16{head.disp[31]}}, head.disp};

	always_ff @(posedge clk) begin
		if (en) begin
			found_s1 <= head.found;
			pos_s1   <= head.pos;
			rel_s1   <= head.found ? rel_nx : 48'd0;
			found_q  <= found_s1;
			pos_q    <= pos_s1;
			tgt_q    <= found_s1 ?
				(rel_s1 + cfg.base + {{16{cfg.addend[31]}}, cfg.addend}) : 48'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vo_q <= 1'b0;
		end else if (en) begin
			v_s1 <= !empty;
			vo_q <= v_s1;
		end
	end

	assign out_valid      = vo_q;
	assign found          = found_q;
	assign match_position = pos_q;
	assign target_address = tgt_q;

endmodule

FILE: design/wildcard_signature_scan_resolve.sv
`timescale 1ns / 1ps
// A result passes from the classifier into the queue, then the resolver stage, then the output
// register, and is held there while the output stalls.
// Throughput: one byte per cycle; the input stalls only when the four-entry result queue is full.
// Reset (arst_n low, asynchronous): clears position, match flag, queue pointers and valids,
// and loads the configuration defaults (pattern length one, everything else zero).
module wildcard_signature_scan_resolve #(
	parameter int MAX_PATTERN  = wsr_pkg::MAX_PATTERN_DEF,
	parameter int WINDOW_DEPTH = wsr_pkg::WINDOW_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] match_position,
	output logic [47:0] target_address
);
	import wsr_pkg::*;

	logic [63:0] pat_q [4];
	logic [5:0]  len_q;
	logic [5:0]  off_q;
	logic [31:0] addend_q;
	logic [47:0] base_q;
	wsr_cfg_t    cfg;
	wsr_evt_t    evt;
	wsr_evt_t    head;
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_empty;

	// configuration writes always complete in one transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				pat_q[k] <= '0;
			end
			len_q    <= 6'd1;
			off_q    <= '0;
			addend_q <= '0;
			base_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PAT0:   pat_q[0] <= cfg_data;
				CFG_PAT1:   pat_q[1] <= cfg_data;
				CFG_PAT2:   pat_q[2] <= cfg_data;
				CFG_PAT3:   pat_q[3] <= cfg_data;
				CFG_LEN:    len_q    <= cfg_data[5:0];
				CFG_OFF:    off_q    <= cfg_data[5:0];
				CFG_ADDEND: addend_q <= cfg_data[31:0];
				CFG_BASE:   base_q   <= cfg_data[47:0];
				default:    ;
			endcase
		end
	end

	// byte 0 of the signature sits in the low byte of the first pattern word
	assign cfg.pattern = {pat_q[3], pat_q[2], pat_q[1], pat_q[0]};
	assign cfg.len     = len_q;
	assign cfg.off     = off_q;
	assign cfg.addend  = addend_q;
	assign cfg.base    = base_q;

	// Front: shift the byte window, test the start position that this byte completes,
	// and queue a hit or the end-of-region miss.
	wsr_front #(
		.MAX_PATTERN (MAX_PATTERN),
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.q_full   (q_full),
		.in_stall (in_stall),
		.push     (push),
		.evt      (evt)
	);

	// Queue: decouple classification from address resolve so each side stalls alone.
	wsr_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (evt),
		.full  (q_full),
		.pop   (pop),
		.dout  (head),
		.empty (q_empty)
	);

	// Back: add position, offset and displacement, then base and addend, and hold the result in the output register.
	wsr_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head          (head),
		.empty         (q_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.found         (found),
		.match_position(match_position),
		.target_address(target_address)
	);

endmodule

FILE: design/wsr_checker.sv
`timescale 1ns / 1ps

module wsr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        out_valid,
	input logic        out_stall,
	input logic        found,
	input logic [31:0] match_position,
	input logic [47:0] target_address
);

	// a miss carries zero position and address
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_position == 32'd0 && target_address == 48'd0)
		else $error("miss result with nonzero fields");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) &&
		$stable(match_position) && $stable(target_address))
		else $error("stalled result changed");

	// configuration writes never wait
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind wildcard_signature_scan_resolve wsr_checker u_wsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.found         (found),
	.match_position(match_position),
	.target_address(target_address)
);

FILE: tb/sv/scan_hit_board_pkg.sv
`timescale 1ns / 1ps

package scan_hit_board_pkg;

	import wsr_pkg::*;

	localparam bit [7:0] WILDCARD = 8'h00;

	typedef struct {
		bit        found;
		bit [31:0] pos;
		bit [47:0] target;
	} scan_hit_t;

	class scan_hit_board;
		bit [63:0] sig_words [4];
		bit [5:0]  len_raw;
		bit [5:0]  off_raw;
		bit [31:0] addend;
		bit [47:0] base;
		bit [7:0]  window [64];
		bit [31:0] position;
		bit        hit_seen;
		scan_hit_t expected_hits [$];
		int        mismatches;

		function new();
			len_raw = 6'd1;
		endfunction

		function void write_reg(cfg_idx_t idx, bit [63:0] value);
			case (idx)
				CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: sig_words[int'(idx)] = value;
				CFG_LEN:    len_raw = value[5:0];
				CFG_OFF:    off_raw = value[5:0];
				CFG_ADDEND: addend = value[31:0];
				CFG_BASE:   base = value[47:0];
				default: ;
			endcase
		endfunction

		// shift in one region byte and queue the result it decides, if any
		function void take_byte(bit [7:0] b, bit fin);
			int        n;
			int        o;
			int        span;
			bit        match;
			bit [7:0]  s;
			bit [31:0] disp;
			bit [31:0] start;
			scan_hit_t h;
			n = (len_raw == 0) ? 1 : ((len_raw > 32) ? 32 : int'(len_raw));
			o = (off_raw > 60) ? 60 : int'(off_raw);
			span = (o + 4 > n) ? o + 4 : n;
			for (int i = 63; i > 0; i--) window[i] = window[i - 1];
			window[0] = b;
			if (!hit_seen && position >= span - 1) begin
				match = 1'b1;
				for (int i = 0; i < n; i++) begin
					s = sig_words[i / 8][(i % 8) * 8 +: 8];
					if (s != WILDCARD && window[span - 1 - i] != s) match = 1'b0;
				end
				if (match) begin
					start = position - (span - 1);
					for (int i = 0; i < 4; i++) disp[i * 8 +: 8] = window[span - 1 - o - i];
					h.found = 1'b1;
					h.pos = start;
					h.target = base + 48'(start) + 48'(o) + {{16{disp[31]}}, disp}
						+ {{16{addend[31]}}, addend};
					expected_hits = {expected_hits, h};
					hit_seen = 1'b1;
				end
			end
			if (fin) begin
				if (!hit_seen) begin
					h.found = 1'b0;
					h.pos = '0;
					h.target = '0;
					expected_hits = {expected_hits, h};
				end
				foreach (window[i]) window[i] = 8'h00;
				position = '0;
				hit_seen = 1'b0;
			end else begin
				position++;
			end
		endfunction

		task log_mismatch(string what);
			$display("%0t ns mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_hit(logic f, logic [31:0] p, logic [47:0] t);
			scan_hit_t e;
			if (expected_hits.size() == 0) begin
				log_mismatch($sformatf("unexpected result found=%0b pos=%0d target=%h", f, p, t));
				return;
			end
			e = expected_hits.pop_front();
			if (f !== e.found)
				log_mismatch($sformatf("found %0b, wanted %0b", f, e.found));
			if (p !== e.pos)
				log_mismatch($sformatf("match_position %0d, wanted %0d", p, e.pos));
			if (t !== e.target)
				log_mismatch($sformatf("target_address %h, wanted %h", t, e.target));
		endtask
	endclass

endpackage

FILE: tb/sv/tb_wildcard_signature_scan_resolve.sv
`timescale 1ns / 1ps

module tb_wildcard_signature_scan_resolve;

	import wsr_pkg::*;
	import scan_hit_board_pkg::*;

	localparam int SETTLE_CYCLES   = 8;     // lets the pipeline drain, with margin
	localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall for the back-pressure phase
	localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer before giving up
	localparam int RANDOM_BYTES    = 500;
	localparam int PHASE_BYTES     = 60;
	localparam int PRESSURE_REGIONS = 40;

	typedef enum {REGION_NOISE, REGION_HIT, REGION_SHORT} region_kind_t;
	typedef enum {SETUP_RANDOM, SETUP_LOW, SETUP_HIGH} setup_mode_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic        found;
	logic [31:0] match_position;
	logic [47:0] target_address;

	scan_hit_board board;
	wsr_cfg_t      cur;            // settings currently loaded in the block
	bit            in_gaps;        // sender inserts idle cycles
	bit            out_gaps;       // receiver inserts stall cycles
	bit            hold_request;   // ask the receiver for one long hold-off
	int            bytes_sent;

	wildcard_signature_scan_resolve uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.match_position (match_position),
		.target_address (target_address)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Observe every transfer at the clock edge. All block inputs change by
	// nonblocking assignment, so the values seen here are the pre-edge ones.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.write_reg(cfg_idx_t'(cfg_index), cfg_data);
			if (in_valid && !in_stall) board.take_byte(data_byte, last_byte);
			if (out_valid && !out_stall) board.check_hit(found, match_position, target_address);
		end
	end

	// Receiver: random stalls, or one long counted hold-off on request.
	initial begin : result_side
		int hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end else if (hold_left == 0 && out_gaps && $urandom_range(0, 3) == 0) begin
				hold_left = gap_length();
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Fail the run if nothing moves for too long.
	initial begin : watchdog
		int stale = 0;
		while (stale < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				stale = 0;
			else
				stale++;
		end
		$display("wildcard_signature_scan_resolve test failed");
		$finish;
	end

	// Offer one register write and hold it until the block takes it. Valid stays
	// high so back-to-back writes go out without a bubble.
	task automatic put_reg(cfg_idx_t idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Load every register; call only while the block is idle.
	task automatic apply_setting(wsr_cfg_t s);
		put_reg(CFG_PAT0, s.pattern[63:0]);
		put_reg(CFG_PAT1, s.pattern[127:64]);
		put_reg(CFG_PAT2, s.pattern[191:128]);
		put_reg(CFG_PAT3, s.pattern[255:192]);
		put_reg(CFG_LEN, 64'(s.len));
		put_reg(CFG_OFF, 64'(s.off));
		put_reg(CFG_ADDEND, 64'(s.addend));
		put_reg(CFG_BASE, 64'(s.base));
		cfg_valid <= 1'b0;
		cur = s;
	endtask

	// Offer one byte and hold it through any input stall, then maybe idle.
	task automatic send_byte(bit [7:0] b, bit fin);
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		if (in_gaps && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (gap_length()) @(posedge clk);
		end
	endtask

	// Send a whole region, flagging its final byte.
	task automatic send_list(input bit [7:0] region_bytes [$]);
		for (int i = 0; i < region_bytes.size(); i++)
			send_byte(region_bytes[i], i == region_bytes.size() - 1);
	endtask

	// Drop valid, wait for every outstanding result, then let the pipeline empty
	// out so bytes that produce nothing are finished as well.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_hits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic wsr_cfg_t random_setting(setup_mode_t mode);
		wsr_cfg_t s;
		int       k;
		// about a third of the signature bytes are wildcards
		for (int i = 0; i < SIG_BYTES; i++)
			s.pattern[i * 8 +: 8] = ($urandom_range(0, 9) < 3) ? WILDCARD
				: 8'($urandom_range(1, 255));
		case (mode)
			SETUP_LOW: begin
				s.len = 6'd0;
				s.off = 6'd0;
				s.addend = 32'h8000_0000;
				s.base = '0;
			end
			SETUP_HIGH: begin
				s.len = 6'd63;
				s.off = 6'd63;
				s.addend = 32'h7FFF_FFFF;
				s.base = '1;
			end
			default: begin
				// keep most signatures short, but hit zero, full size and oversize
				k = $urandom_range(0, 9);
				s.len = (k == 0) ? 6'd0 : (k == 1) ? 6'd32
					: (k == 2) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(1, 8));
				k = $urandom_range(0, 9);
				s.off = (k == 0) ? 6'd60 : (k == 1) ? 6'($urandom_range(61, 63))
					: 6'($urandom_range(0, 8));
				k = $urandom_range(0, 6);
				s.addend = (k == 0) ? 32'h8000_0000 : (k == 1) ? 32'h7FFF_FFFF : $urandom;
				k = $urandom_range(0, 6);
				s.base = (k == 0) ? 48'h0 : (k == 1) ? '1 : {16'($urandom), 32'($urandom)};
			end
		endcase
		return s;
	endfunction

	// Random byte that often borrows a signature byte, so partial matches show up.
	function automatic bit [7:0] noise_byte(int n);
		if ($urandom_range(0, 3) == 0) return cur.pattern[$urandom_range(0, n - 1) * 8 +: 8];
		return 8'($urandom);
	endfunction

	// Build a region around the current setting: with a planted signature and room
	// for its displacement, with the region cut short before the displacement ends,
	// or plain noise.
	task automatic send_region(region_kind_t kind);
		bit [7:0] region_bytes [$];
		int       n;
		int       o;
		int       span;
		int       p;
		int       total;
		n = (cur.len == 0) ? 1 : ((cur.len > 32) ? 32 : int'(cur.len));
		o = (cur.off > 60) ? 60 : int'(cur.off);
		span = (o + 4 > n) ? o + 4 : n;
		p = $urandom_range(0, 8);
		case (kind)
			REGION_HIT:   total = p + span + $urandom_range(0, 8);
			REGION_SHORT: total = p + $urandom_range(1, span - 1);
			default:      total = $urandom_range(1, span + 12);
		endcase
		for (int i = 0; i < total; i++) region_bytes = {region_bytes, noise_byte(n)};
		if (kind != REGION_NOISE) begin
			for (int i = 0; i < 4; i++)
				if (p + o + i < total) region_bytes[p + o + i] = 8'($urandom);
			// signature last, so it wins where it overlaps the displacement
			for (int i = 0; i < n; i++)
				if (cur.pattern[i * 8 +: 8] != WILDCARD && p + i < total)
					region_bytes[p + i] = cur.pattern[i * 8 +: 8];
		end
		send_list(region_bytes);
	endtask

	initial begin : stimulus
		bit [7:0] region_bytes [$];
		wsr_cfg_t s;
		int       phase;
		int       random_start;
		int       phase_start;
		int       k;
		board = new();
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_PAT0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		last_byte <= 1'b0;
		in_gaps = 1'b0;
		out_gaps = 1'b0;
		hold_request = 1'b0;
		bytes_sent = 0;
		cur = '0;
		cur.len = 6'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one wildcard byte, displacement right at the match start.
		// A single-byte region cannot hold the displacement.
		region_bytes = '{8'h00};
		send_list(region_bytes);
		// all ones: displacement of minus one, target wraps to the top of 48 bits
		region_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_list(region_bytes);
		// most negative displacement; bytes after the hit are ignored
		region_bytes = '{8'h00, 8'h00, 8'h00, 8'h80, 8'h5A, 8'h3C};
		send_list(region_bytes);
		settle();

		// Three-byte signature with a wildcard in the middle, extreme addend and base.
		s = '0;
		s.pattern[23:0] = {8'h7E, WILDCARD, 8'hC3};
		s.len = 6'd3;
		s.off = 6'd1;
		s.addend = 32'h7FFF_FFFF;
		s.base = '1;
		apply_setting(s);
		region_bytes = '{8'h7E, 8'hC3, 8'h11, 8'h7E, 8'h04, 8'h00, 8'h00};
		send_list(region_bytes);
		// near miss on every start: no match
		region_bytes = '{8'hC3, 8'h22, 8'h7F, 8'h00, 8'h00, 8'h01};
		send_list(region_bytes);
		settle();

		// Back-pressure: every short region yields a result while the
		// receiver holds off, so the result queue fills and the input stalls.
		s = random_setting(SETUP_RANDOM);
		s.len = 6'd1;
		s.off = 6'd0;
		s.pattern[7:0] = WILDCARD;
		apply_setting(s);
		hold_request = 1'b1;
		repeat (PRESSURE_REGIONS) begin
			region_bytes.delete();
			repeat ($urandom_range(1, 5)) region_bytes = {region_bytes, 8'($urandom)};
			send_list(region_bytes);
		end
		// pause the sender until every result is back
		settle();

		// Random phases: fresh settings each time, extremes first, with the
		// sender and receiver idling on and off between phases.
		phase = 0;
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			apply_setting(random_setting((phase == 0) ? SETUP_LOW
				: (phase == 1) ? SETUP_HIGH : SETUP_RANDOM));
			in_gaps = (phase % 3 != 2);
			out_gaps = (phase % 4 != 3);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES
					&& bytes_sent - random_start < RANDOM_BYTES) begin
				k = $urandom_range(0, 19);
				send_region((k < 12) ? REGION_HIT : (k < 15) ? REGION_SHORT : REGION_NOISE);
			end
			settle();
			phase++;
		end

		if (board.mismatches == 0)
			$display("wildcard_signature_scan_resolve test passed");
		else
			$display("wildcard_signature_scan_resolve test failed");
		$finish;
	end

endmodule

FILE: sim.f
design/wsr_pkg.sv
design/wsr_front.sv
design/wsr_fifo.sv
design/wsr_back.sv
design/wildcard_signature_scan_resolve.sv
design/wsr_checker.sv
tb/sv/scan_hit_board_pkg.sv
tb/sv/tb_wildcard_signature_scan_resolve.sv
